@@ sv/tgc_pkg.sv @@
// shared types and constants for the tweezer grid compaction block
`default_nettype none
package tgc_pkg;

    localparam int OPW  = 2;
    localparam int PW   = 6;
    localparam int STW  = 2;
    localparam int IDXW = 10;
    localparam int RNDW = 16;
    localparam int S_DW = 16;
    localparam int M_DW = 40;

    localparam logic [OPW-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPW-1:0] OP_LOAD  = 2'd1;
    localparam logic [OPW-1:0] OP_ADV   = 2'd2;

    localparam logic [STW-1:0] ST_OK    = 2'd0;
    localparam logic [STW-1:0] ST_OCC   = 2'd1;
    localparam logic [STW-1:0] ST_FULL  = 2'd2;
    localparam logic [STW-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DEC,
        S_LD_CHK,
        S_DIV,
        S_ADV_RD,
        S_ADV_CAND,
        S_ADV_CHK1,
        S_ADV_CHK2,
        S_ADV_CLR,
        S_ADV_FIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_BLANK,
        RES_OCC,
        RES_FULL,
        RES_EMPTY
    } t_res;

    typedef struct packed {
        logic cap;
        logic clr_state;
        logic sweep;
        logic ld_commit;
        logic div_start;
        logic div_step;
        logic adv_rd;
        logic adv_cand;
        logic rd_c2;
        logic take_c1;
        logic take_c2;
        logic clr_old;
        logic adv_fin;
        logic out_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           ld_oob;
        logic           occ;
        logic           full;
        logic           cnt_zero;
        logic           tgt_valid;
        logic           div_last;
        logic           sweep_last;
        logic           cand1_ok;
        logic           cand2_ok;
        logic           out_busy;
    } t_sts;

endpackage
`default_nettype wire

@@ sv/tgc_ctrl.sv @@
// controller state machine for the tweezer grid compaction block
`default_nettype none
module tgc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire tgc_pkg::t_sts i_sts,
    output tgc_pkg::t_cmd      o_cmd
);

    tgc_pkg::t_state r_state, n_state;
    logic            r_from_op, n_from_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tgc_pkg::S_SWEEP;
            r_from_op <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_op <= n_from_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_from_op  = r_from_op;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            tgc_pkg::S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_from_op ? tgc_pkg::S_DONE : tgc_pkg::S_IDLE;
                end
            end
            tgc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = tgc_pkg::S_DEC;
                end
            end
            tgc_pkg::S_DEC: begin
                unique case (i_sts.op)
                    tgc_pkg::OP_CLEAR: begin
                        o_cmd.clr_state = 1'b1;
                        o_cmd.res       = tgc_pkg::RES_BLANK;
                        n_from_op       = 1'b1;
                        n_state         = tgc_pkg::S_SWEEP;
                    end
                    tgc_pkg::OP_LOAD: begin
                        if (i_sts.ld_oob) begin
                            o_cmd.res = tgc_pkg::RES_OCC;
                            n_state   = tgc_pkg::S_DONE;
                        end else begin
                            n_state = tgc_pkg::S_LD_CHK;
                        end
                    end
                    tgc_pkg::OP_ADV: begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.res = tgc_pkg::RES_EMPTY;
                            n_state   = tgc_pkg::S_DONE;
                        end else if (!i_sts.tgt_valid) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = tgc_pkg::S_DIV;
                        end else begin
                            n_state = tgc_pkg::S_ADV_RD;
                        end
                    end
                    default: begin
                        o_cmd.res = tgc_pkg::RES_BLANK;
                        n_state   = tgc_pkg::S_DONE;
                    end
                endcase
            end
            tgc_pkg::S_LD_CHK: begin
                if (i_sts.occ) begin
                    o_cmd.res = tgc_pkg::RES_OCC;
                end else if (i_sts.full) begin
                    o_cmd.res = tgc_pkg::RES_FULL;
                end else begin
                    o_cmd.ld_commit = 1'b1;
                end
                n_state = tgc_pkg::S_DONE;
            end
            tgc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = tgc_pkg::S_ADV_RD;
                end
            end
            tgc_pkg::S_ADV_RD: begin
                o_cmd.adv_rd = 1'b1;
                n_state      = tgc_pkg::S_ADV_CAND;
            end
            tgc_pkg::S_ADV_CAND: begin
                o_cmd.adv_cand = 1'b1;
                n_state = i_sts.cand1_ok ? tgc_pkg::S_ADV_CHK1 : tgc_pkg::S_ADV_FIN;
            end
            tgc_pkg::S_ADV_CHK1: begin
                if (!i_sts.occ) begin
                    o_cmd.take_c1 = 1'b1;
                    n_state       = tgc_pkg::S_ADV_CLR;
                end else if (i_sts.cand2_ok) begin
                    o_cmd.rd_c2 = 1'b1;
                    n_state     = tgc_pkg::S_ADV_CHK2;
                end else begin
                    n_state = tgc_pkg::S_ADV_FIN;
                end
            end
            tgc_pkg::S_ADV_CHK2: begin
                if (!i_sts.occ) begin
                    o_cmd.take_c2 = 1'b1;
                    n_state       = tgc_pkg::S_ADV_CLR;
                end else begin
                    n_state = tgc_pkg::S_ADV_FIN;
                end
            end
            tgc_pkg::S_ADV_CLR: begin
                o_cmd.clr_old = 1'b1;
                n_state       = tgc_pkg::S_ADV_FIN;
            end
            tgc_pkg::S_ADV_FIN: begin
                o_cmd.adv_fin = 1'b1;
                n_state       = tgc_pkg::S_DONE;
            end
            tgc_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_from_op      = 1'b0;
                    n_state        = tgc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tgc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/tgc_dp.sv @@
// datapath: grid and position memories, divider, move logic and result register
`default_nettype none
module tgc_dp #(
    parameter int GRID_SIDE    = 64,
    parameter int MAX_TWEEZERS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tgc_pkg::t_cmd            i_cmd,
    output tgc_pkg::t_sts                 o_sts,
    input  wire logic [tgc_pkg::S_DW-1:0] i_s_tdata,
    input  wire logic [tgc_pkg::OPW-1:0]  i_s_tuser,
    input  wire logic                     i_m_tready,
    output logic                          o_m_tvalid,
    output logic [tgc_pkg::M_DW-1:0]      o_m_tdata,
    output logic [tgc_pkg::STW-1:0]       o_m_tuser,
    output logic                          o_m_tlast
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int GAW   = $clog2(CELLS);
    localparam int IW    = (MAX_TWEEZERS > 1) ? $clog2(MAX_TWEEZERS) : 1;
    localparam int CNW   = $clog2(MAX_TWEEZERS + 1);
    localparam int SUMW  = $clog2((GRID_SIDE - 1) * MAX_TWEEZERS + 1);
    localparam int DCW   = $clog2(SUMW);
    localparam int RW    = CNW + 1;
    localparam int PW    = tgc_pkg::PW;

    function automatic logic [GAW-1:0] f_cell(input logic [CW-1:0] r, input logic [CW-1:0] c);
        f_cell = GAW'(r) * GAW'(GRID_SIDE) + GAW'(c);
    endfunction

    // memories
    logic             r_grid [CELLS];
    logic             r_gq;
    logic             w_gwe, w_gwd;
    logic [GAW-1:0]   w_gwa, w_gra;
    logic [2*CW-1:0]  r_store [MAX_TWEEZERS];
    logic [2*CW-1:0]  r_sq;
    logic             w_swe;
    logic [IW-1:0]    w_swa, w_sra;
    logic [2*CW-1:0]  w_swd;

    // state
    logic [CNW-1:0]   r_cnt;
    logic [SUMW-1:0]  r_rsum, r_csum;
    logic [CW-1:0]    r_tr, r_tc;
    logic             r_tv;
    logic [IW-1:0]    r_cur;
    logic             r_any;
    logic [tgc_pkg::RNDW-1:0] r_rnd;
    logic             r_done;
    logic [GAW-1:0]   r_swp;
    logic             r_out_valid;

    // payload
    logic [tgc_pkg::OPW-1:0] r_op;
    logic [PW-1:0]    r_row, r_col;
    logic [SUMW-1:0]  r_rn, r_cn;
    logic [CNW-1:0]   r_rr, r_cr;
    logic [DCW-1:0]   r_dcnt;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_r, r_c, r_nr, r_nc;
    logic [CW-1:0]    r_c1r, r_c1c, r_c2r, r_c2c;
    logic             r_c2v, r_mv;
    logic [tgc_pkg::STW-1:0] r_res_st;
    logic [IW-1:0]    r_res_idx;
    logic [PW-1:0]    r_res_r, r_res_c;
    logic             r_res_mv, r_res_end, r_res_blank;
    logic [tgc_pkg::M_DW-1:0] r_out_data;
    logic [tgc_pkg::STW-1:0]  r_out_user;
    logic             r_out_last;

    // combinational
    logic [CW-1:0]    w_ldr, w_ldc, w_qr, w_qc, w_dr, w_dc, w_rstep, w_cstep;
    logic [CW-1:0]    w_c1r, w_c1c, w_c2r, w_c2c;
    logic             w_rok, w_cok, w_rfirst, w_c1v, w_c2v;
    logic [GAW-1:0]   w_ld_cell;
    logic [IW-1:0]    w_adv_idx;
    logic [RW-1:0]    w_rt, w_ct;
    logic             w_rge, w_cge;
    logic             w_last, w_any_n;

    assign w_ldr     = CW'(r_row);
    assign w_ldc     = CW'(r_col);
    assign w_ld_cell = f_cell(w_ldr, w_ldc);
    assign w_adv_idx = (r_cnt <= CNW'(r_cur)) ? '0 : r_cur;

    assign w_qr    = r_sq[2*CW-1:CW];
    assign w_qc    = r_sq[CW-1:0];
    assign w_dr    = (w_qr > r_tr) ? w_qr - r_tr : r_tr - w_qr;
    assign w_dc    = (w_qc > r_tc) ? w_qc - r_tc : r_tc - w_qc;
    assign w_rstep = (w_qr > r_tr) ? w_qr - 1'b1 : w_qr + 1'b1;
    assign w_cstep = (w_qc > r_tc) ? w_qc - 1'b1 : w_qc + 1'b1;
    assign w_rok   = (w_qr != r_tr);
    assign w_cok   = (w_qc != r_tc);
    assign w_rfirst = w_rok && (w_dr >= w_dc);

    // up to two distinct neighbor candidates in try order
    always_comb begin
        w_c1r = w_qr;
        w_c1c = w_qc;
        w_c2r = w_qr;
        w_c2c = w_qc;
        w_c1v = 1'b0;
        w_c2v = 1'b0;
        if (w_rfirst) begin
            w_c1r = w_rstep;
            w_c1v = 1'b1;
            w_c2c = w_cstep;
            w_c2v = w_cok;
        end else if (w_cok) begin
            w_c1c = w_cstep;
            w_c1v = 1'b1;
            w_c2r = w_rstep;
            w_c2v = w_rok;
        end else begin
            w_c1r = w_rstep;
            w_c1v = w_rok;
        end
    end

    assign w_rt  = {r_rr, r_rn[SUMW-1]};
    assign w_ct  = {r_cr, r_cn[SUMW-1]};
    assign w_rge = (w_rt >= RW'(r_cnt));
    assign w_cge = (w_ct >= RW'(r_cnt));

    assign w_last  = ((CNW'(r_idx) + 1'b1) >= r_cnt);
    assign w_any_n = r_any | r_mv;

    // grid port muxes
    always_comb begin
        w_gwe = 1'b0;
        w_gwd = 1'b0;
        w_gwa = f_cell(r_r, r_c);
        w_gra = w_ld_cell;
        if (i_cmd.sweep) begin
            w_gwe = 1'b1;
            w_gwa = r_swp;
        end
        if (i_cmd.ld_commit) begin
            w_gwe = 1'b1;
            w_gwd = 1'b1;
            w_gwa = w_ld_cell;
        end
        if (i_cmd.take_c1) begin
            w_gwe = 1'b1;
            w_gwd = 1'b1;
            w_gwa = f_cell(r_c1r, r_c1c);
        end
        if (i_cmd.take_c2) begin
            w_gwe = 1'b1;
            w_gwd = 1'b1;
            w_gwa = f_cell(r_c2r, r_c2c);
        end
        if (i_cmd.clr_old) begin
            w_gwe = 1'b1;
        end
        if (i_cmd.adv_cand) begin
            w_gra = f_cell(w_c1r, w_c1c);
        end
        if (i_cmd.rd_c2) begin
            w_gra = f_cell(r_c2r, r_c2c);
        end
    end

    // position store port muxes
    always_comb begin
        w_swe = i_cmd.ld_commit | i_cmd.clr_old;
        w_swa = i_cmd.ld_commit ? IW'(r_cnt) : r_idx;
        w_swd = i_cmd.ld_commit ? {w_ldr, w_ldc} : {r_nr, r_nc};
        w_sra = w_adv_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_gwe) begin
            r_grid[w_gwa] <= w_gwd;
        end
        r_gq <= r_grid[w_gra];
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_store[w_swa] <= w_swd;
        end
        r_sq <= r_store[w_sra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rsum      <= '0;
            r_csum      <= '0;
            r_tr        <= '0;
            r_tc        <= '0;
            r_tv        <= 1'b0;
            r_cur       <= '0;
            r_any       <= 1'b0;
            r_rnd       <= '0;
            r_done      <= 1'b0;
            r_swp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_state) begin
                r_cnt  <= '0;
                r_rsum <= '0;
                r_csum <= '0;
                r_tr   <= '0;
                r_tc   <= '0;
                r_tv   <= 1'b0;
                r_cur  <= '0;
                r_any  <= 1'b0;
                r_rnd  <= '0;
                r_done <= 1'b0;
                r_swp  <= '0;
            end
            if (i_cmd.sweep) begin
                r_swp <= r_swp + 1'b1;
            end
            if (i_cmd.ld_commit) begin
                r_cnt  <= r_cnt + 1'b1;
                r_rsum <= r_rsum + SUMW'(r_row);
                r_csum <= r_csum + SUMW'(r_col);
                r_tv   <= 1'b0;
                r_cur  <= '0;
                r_any  <= 1'b0;
                r_done <= 1'b0;
            end
            if (i_cmd.adv_rd && !r_tv) begin
                r_tr <= CW'(r_rn);
                r_tc <= CW'(r_cn);
                r_tv <= 1'b1;
            end
            if (i_cmd.adv_fin) begin
                if (w_last) begin
                    r_cur <= '0;
                    r_any <= 1'b0;
                    if (r_rnd != '1) begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                    if (!w_any_n) begin
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cur <= r_idx + 1'b1;
                    r_any <= w_any_n;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_s_tuser;
            r_row <= i_s_tdata[PW-1:0];
            r_col <= i_s_tdata[2*PW-1:PW];
        end
        if (i_cmd.div_start) begin
            r_rn   <= r_rsum;
            r_cn   <= r_csum;
            r_rr   <= '0;
            r_cr   <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rn   <= {r_rn[SUMW-2:0], w_rge};
            r_cn   <= {r_cn[SUMW-2:0], w_cge};
            r_rr   <= w_rge ? CNW'(w_rt - RW'(r_cnt)) : CNW'(w_rt);
            r_cr   <= w_cge ? CNW'(w_ct - RW'(r_cnt)) : CNW'(w_ct);
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.adv_rd) begin
            r_idx <= w_adv_idx;
        end
        if (i_cmd.adv_cand) begin
            r_r   <= w_qr;
            r_c   <= w_qc;
            r_nr  <= w_qr;
            r_nc  <= w_qc;
            r_c1r <= w_c1r;
            r_c1c <= w_c1c;
            r_c2r <= w_c2r;
            r_c2c <= w_c2c;
            r_c2v <= w_c2v;
            r_mv  <= 1'b0;
        end
        if (i_cmd.take_c1) begin
            r_nr <= r_c1r;
            r_nc <= r_c1c;
            r_mv <= 1'b1;
        end
        if (i_cmd.take_c2) begin
            r_nr <= r_c2r;
            r_nc <= r_c2c;
            r_mv <= 1'b1;
        end
        unique case (i_cmd.res)
            tgc_pkg::RES_NONE: begin
            end
            tgc_pkg::RES_BLANK: begin
                r_res_st    <= tgc_pkg::ST_OK;
                r_res_idx   <= '0;
                r_res_r     <= '0;
                r_res_c     <= '0;
                r_res_mv    <= 1'b0;
                r_res_end   <= 1'b0;
                r_res_blank <= 1'b1;
            end
            tgc_pkg::RES_OCC, tgc_pkg::RES_FULL: begin
                r_res_st    <= (i_cmd.res == tgc_pkg::RES_OCC) ? tgc_pkg::ST_OCC
                                                                : tgc_pkg::ST_FULL;
                r_res_idx   <= '0;
                r_res_r     <= r_row;
                r_res_c     <= r_col;
                r_res_mv    <= 1'b0;
                r_res_end   <= 1'b0;
                r_res_blank <= 1'b0;
            end
            tgc_pkg::RES_EMPTY: begin
                r_res_st    <= tgc_pkg::ST_EMPTY;
                r_res_idx   <= '0;
                r_res_r     <= '0;
                r_res_c     <= '0;
                r_res_mv    <= 1'b0;
                r_res_end   <= 1'b0;
                r_res_blank <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.ld_commit) begin
            r_res_st    <= tgc_pkg::ST_OK;
            r_res_idx   <= IW'(r_cnt);
            r_res_r     <= r_row;
            r_res_c     <= r_col;
            r_res_mv    <= 1'b0;
            r_res_end   <= 1'b0;
            r_res_blank <= 1'b0;
        end
        if (i_cmd.adv_fin) begin
            r_res_st    <= tgc_pkg::ST_OK;
            r_res_idx   <= r_idx;
            r_res_r     <= PW'(r_nr);
            r_res_c     <= PW'(r_nc);
            r_res_mv    <= r_mv;
            r_res_end   <= w_last;
            r_res_blank <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_user <= r_res_st;
            r_out_last <= r_res_end;
            r_out_data <= {r_res_blank ? '0 : r_rnd,
                           r_done & ~r_res_blank,
                           r_res_mv,
                           r_res_c,
                           r_res_r,
                           tgc_pkg::IDXW'(r_res_idx)};
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.ld_oob     = (32'(r_row) >= 32'(GRID_SIDE)) || (32'(r_col) >= 32'(GRID_SIDE));
        o_sts.occ        = r_gq;
        o_sts.full       = (r_cnt == CNW'(MAX_TWEEZERS));
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.tgt_valid  = r_tv;
        o_sts.div_last   = (r_dcnt == DCW'(SUMW - 1));
        o_sts.sweep_last = (r_swp == GAW'(CELLS - 1));
        o_sts.cand1_ok   = w_c1v;
        o_sts.cand2_ok   = r_c2v;
        o_sts.out_busy   = r_out_valid & ~i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

@@ sv/tweezer_grid_compaction.sv @@
// top level: tweezer grid compaction, controller plus datapath
// one transaction at a time; a load goes via LD_CHK, an advance ADV_RD to ADV_FIN
// the first advance after a load adds the mean divider, one cycle per sum bit (16 default)
// a clear op sweeps the occupancy memory one cell a cycle, all GRID_SIDE*GRID_SIDE cells
// synchronous active-low reset, then the same sweep runs with tready low
// the output register lets a new transaction in while a result waits
`default_nettype none
module tweezer_grid_compaction #(
    parameter int GRID_SIDE    = 64,
    parameter int MAX_TWEEZERS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [tgc_pkg::S_DW-1:0] i_s_tdata,  // row, col
    input  wire logic [tgc_pkg::OPW-1:0]  i_s_tuser,  // op
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // tweezer_index, new_row, new_col, moved, converged, round_number
    output logic [tgc_pkg::M_DW-1:0]      o_m_tdata,
    output logic [tgc_pkg::STW-1:0]       o_m_tuser,  // status
    output logic                          o_m_tlast
);

    tgc_pkg::t_cmd w_cmd;
    tgc_pkg::t_sts w_sts;

    tgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tgc_dp #(
        .GRID_SIDE    (GRID_SIDE),
        .MAX_TWEEZERS (MAX_TWEEZERS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
